// ----- rtl/core/brcc_pkg.sv -----
// Shared types, constants and widths for the balance robot cascade controller.
package brcc_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Fraction bits of the fixed-point gains and of the speed state.
    localparam int FRAC_BITS = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BALANCE_KP    = 3'd0,
        CFG_BALANCE_KD    = 3'd1,
        CFG_SPEED_KP      = 3'd2,
        CFG_SPEED_KI      = 3'd3,
        CFG_TURN_KP       = 3'd4,
        CFG_TURN_KD       = 3'd5,
        CFG_BALANCE_ANGLE = 3'd6,
        CFG_PWM_LIMIT     = 3'd7
    } cfg_index_t;

    localparam logic signed [18:0] RST_BALANCE_KP    = 19'sd74240;
    localparam logic signed [16:0] RST_BALANCE_KD    = 17'sd256;
    localparam logic signed [16:0] RST_SPEED_KP      = 17'sd23040;
    localparam logic signed [16:0] RST_SPEED_KI      = 17'sd154;
    localparam logic signed [16:0] RST_TURN_KP       = -17'sd7680;
    localparam logic signed [16:0] RST_TURN_KD       = -17'sd179;
    localparam logic signed [15:0] RST_BALANCE_ANGLE = -16'sd200;
    localparam logic [14:0]        RST_PWM_LIMIT     = 15'd7200;

    // Remote byte codes.
    localparam logic [7:0] REM_STOP    = 8'd48;
    localparam logic [7:0] REM_STOP_LF = 8'd10;
    localparam logic [7:0] REM_FWD     = 8'd49;
    localparam logic [7:0] REM_BACK    = 8'd50;
    localparam logic [7:0] REM_LEFT    = 8'd51;
    localparam logic [7:0] REM_RIGHT   = 8'd52;

    // Direction latch flags.
    localparam logic [3:0] DIR_NONE  = 4'b0000;
    localparam logic [3:0] DIR_FWD   = 4'b0001;
    localparam logic [3:0] DIR_BACK  = 4'b0010;
    localparam logic [3:0] DIR_LEFT  = 4'b0100;
    localparam logic [3:0] DIR_RIGHT = 4'b1000;

    localparam logic signed [7:0]  TARGET_MAX      = 8'sd100;
    localparam logic signed [7:0]  TARGET_MIN      = -8'sd100;
    localparam logic signed [6:0]  TURN_CMD        = 7'sd30;
    localparam logic signed [15:0] PITCH_CLEAR_LIM = 16'sd4000;

    // Datapath widths.
    localparam int FS_W       = FRAC_BITS + 18;
    localparam int INT_W      = FRAC_BITS + 15;
    localparam int FSN_W      = FRAC_BITS + 21;
    localparam int INT_SUM_W  = FRAC_BITS + 20;
    localparam int BAL_ACC_W  = 41;

    // Division by constants through reciprocal products. The speed filter
    // divides by 5; the upright scale 100 * 2^F is 25 * 2^(F+2), so the
    // power of two is shifted off first and the rest is a division by 25.
    // Each reciprocal is 2^s / d rounded up with s = DIV_W + ceil(log2 d),
    // which makes the shifted product the exact floor for every DIV_W-bit
    // dividend.
    localparam int BAL_PRE_SH   = FRAC_BITS + 2;
    localparam int DIV_W        = imax(FSN_W, BAL_ACC_W - BAL_PRE_SH);
    localparam int RECIP_W      = DIV_W + 1;
    localparam int DIV_PROD_W   = DIV_W + RECIP_W;
    localparam int FS_RECIP_SH  = DIV_W + 3;
    localparam int BAL_RECIP_SH = DIV_W + 5;
    localparam logic [RECIP_W-1:0] FS_RECIP =
        RECIP_W'(((64'd1 << FS_RECIP_SH) + 64'd4) / 64'd5);
    localparam logic [RECIP_W-1:0] BAL_RECIP =
        RECIP_W'(((64'd1 << BAL_RECIP_SH) + 64'd24) / 64'd25);

    localparam int MUL_A_W    = imax(FS_W, 23);
    localparam int MUL_B_W    = 19;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int SPD_ACC_W  = FS_W + 18;
    localparam int TURN_ACC_W = 34;
    localparam int BAL_Q_W    = DIV_W + 1;
    localparam int SPD_T_W    = SPD_ACC_W - 2 * FRAC_BITS;
    localparam int TURN_T_W   = TURN_ACC_W - FRAC_BITS;
    localparam int SUM_W      = imax(BAL_Q_W, imax(SPD_T_W, TURN_T_W)) + 2;

    localparam int INT_LIMIT = 10000 << FRAC_BITS;

    localparam logic signed [SPD_ACC_W-1:0] SPD_RND =
        SPD_ACC_W'((64'd1 << (2 * FRAC_BITS)) - 64'd1);
    localparam logic signed [TURN_ACC_W-1:0] TURN_RND =
        TURN_ACC_W'((64'd1 << FRAC_BITS) - 64'd1);

    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] left_count;
        logic signed [15:0] right_count;
        logic [7:0]         remote_code;
    } brcc_in_t;

    typedef struct packed {
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic               integral_cleared;
    } brcc_out_t;

    typedef enum logic [2:0] {
        MUL_NONE    = 3'd0,
        MUL_BAL_KP  = 3'd1,
        MUL_BAL_KD  = 3'd2,
        MUL_TURN_KD = 3'd3,
        MUL_TURN_KP = 3'd4,
        MUL_SPD_KP  = 3'd5,
        MUL_SPD_KI  = 3'd6
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_BKD,
        ST_MUL_TKD,
        ST_MUL_TKP,
        ST_WAIT_FS,
        ST_FS_UPD,
        ST_INT_UPD,
        ST_MUL_SKP,
        ST_MUL_SKI,
        ST_DRAIN,
        ST_WAIT_BAL,
        ST_RESULT_PREP,
        ST_RESULT
    } brcc_state_t;

    typedef struct packed {
        logic    load;
        logic    prep;
        logic    div_fs;
        logic    div_bal;
        mul_op_t mul_op;
        logic    fs_upd;
        logic    int_upd;
        logic    int_clr;
        logic    result_prep;
        logic    out_load;
    } brcc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_stall;
    } brcc_status_t;

endpackage

// ----- rtl/core/brcc_div.sv -----
// Unsigned division by five or by twenty-five through a registered reciprocal product.
module brcc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         use_bal,
    input  logic [brcc_pkg::DIV_W-1:0]   dividend,
    output logic                         busy,
    output logic [brcc_pkg::DIV_W-1:0]   quotient
);

    logic [brcc_pkg::DIV_W-1:0]      x_reg;
    logic                            bal_reg;
    logic                            busy_reg;
    logic [brcc_pkg::DIV_PROD_W-1:0] prod_reg;
    logic [brcc_pkg::RECIP_W-1:0]    recip;
    logic [brcc_pkg::DIV_PROD_W-1:0] prod_sh;

    // The operand is captured at start, multiplied in the next cycle, and the
    // quotient is the product shifted down by the reciprocal's scale.
    always_comb begin
        recip   = bal_reg ? brcc_pkg::BAL_RECIP : brcc_pkg::FS_RECIP;
        prod_sh = bal_reg ? (prod_reg >> brcc_pkg::BAL_RECIP_SH)
                          : (prod_reg >> brcc_pkg::FS_RECIP_SH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= dividend;
            bal_reg <= use_bal;
        end
        if (busy_reg) begin
            prod_reg <= brcc_pkg::DIV_PROD_W'(x_reg) * brcc_pkg::DIV_PROD_W'(recip);
        end
    end

    assign busy     = busy_reg;
    assign quotient = prod_sh[brcc_pkg::DIV_W-1:0];

endmodule

// ----- rtl/core/brcc_dp.sv -----
// Datapath: registers, shared multiplier, divider, accumulators and result register.
module brcc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  brcc_pkg::brcc_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output brcc_pkg::brcc_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [brcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [brcc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  brcc_pkg::brcc_cmd_t                 cmd,
    output brcc_pkg::brcc_status_t              status
);

    // Configuration registers.
    logic signed [18:0] balance_kp_reg;
    logic signed [16:0] balance_kd_reg;
    logic signed [16:0] speed_kp_reg;
    logic signed [16:0] speed_ki_reg;
    logic signed [16:0] turn_kp_reg;
    logic signed [16:0] turn_kd_reg;
    logic signed [15:0] balance_angle_reg;
    logic [14:0]        pwm_limit_reg;

    // Controller state kept across requests.
    logic signed [brcc_pkg::FS_W-1:0]  fs_reg;
    logic signed [brcc_pkg::INT_W-1:0] integ_reg;
    logic signed [7:0]                 target_reg;
    logic [3:0]                        dir_latch_reg;

    // Per-request working registers.
    brcc_pkg::brcc_in_t                      in_reg;
    logic signed [brcc_pkg::MUL_P_W-1:0]     prod_reg;
    brcc_pkg::mul_op_t                       prod_dst_reg;
    logic signed [brcc_pkg::BAL_ACC_W-1:0]   bal_acc_reg;
    logic signed [brcc_pkg::TURN_ACC_W-1:0]  turn_acc_reg;
    logic signed [brcc_pkg::SPD_ACC_W-1:0]   spd_acc_reg;
    logic                                    q_neg_reg;
    logic signed [brcc_pkg::SUM_W-1:0]       base_reg;
    logic signed [brcc_pkg::SUM_W-1:0]       turn_reg;
    logic                                    m_valid_reg;
    brcc_pkg::brcc_out_t                     m_data_reg;

    logic [3:0]                              dir_latch_next;
    logic signed [7:0]                       target_next;
    logic signed [6:0]                       turn_cmd;
    logic signed [16:0]                      bias;
    logic signed [22:0]                      prate_x100;
    logic signed [brcc_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [brcc_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [brcc_pkg::MUL_P_W-1:0]     prod_next;
    logic signed [16:0]                      wheel_sum;
    logic signed [brcc_pkg::FSN_W-1:0]       fsn;
    logic [brcc_pkg::FSN_W-1:0]              fsn_mag;
    logic [brcc_pkg::BAL_ACC_W-1:0]          bal_mag;
    logic                                    div_start;
    logic [brcc_pkg::DIV_W-1:0]              div_dividend;
    logic                                    div_busy;
    logic [brcc_pkg::DIV_W-1:0]              div_q;
    logic signed [brcc_pkg::BAL_Q_W-1:0]     q_s;
    logic signed [brcc_pkg::INT_SUM_W-1:0]   isum;
    logic signed [brcc_pkg::INT_SUM_W-1:0]   int_lim;
    logic signed [brcc_pkg::SPD_ACC_W-1:0]   spd_adj;
    logic signed [brcc_pkg::SPD_ACC_W-1:0]   spd_sh;
    logic signed [brcc_pkg::SPD_T_W-1:0]     spd_t;
    logic signed [brcc_pkg::TURN_ACC_W-1:0]  turn_adj;
    logic signed [brcc_pkg::TURN_ACC_W-1:0]  turn_sh;
    logic signed [brcc_pkg::TURN_T_W-1:0]    turn_t;
    logic signed [brcc_pkg::SUM_W-1:0]       lim_s;
    logic signed [brcc_pkg::SUM_W-1:0]       left_sum;
    logic signed [brcc_pkg::SUM_W-1:0]       right_sum;
    logic signed [brcc_pkg::SUM_W-1:0]       left_clip;
    logic signed [brcc_pkg::SUM_W-1:0]       right_clip;
    logic                                    pitch_tilted;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            balance_kp_reg    <= brcc_pkg::RST_BALANCE_KP;
            balance_kd_reg    <= brcc_pkg::RST_BALANCE_KD;
            speed_kp_reg      <= brcc_pkg::RST_SPEED_KP;
            speed_ki_reg      <= brcc_pkg::RST_SPEED_KI;
            turn_kp_reg       <= brcc_pkg::RST_TURN_KP;
            turn_kd_reg       <= brcc_pkg::RST_TURN_KD;
            balance_angle_reg <= brcc_pkg::RST_BALANCE_ANGLE;
            pwm_limit_reg     <= brcc_pkg::RST_PWM_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (brcc_pkg::cfg_index_t'(cfg_index))
                brcc_pkg::CFG_BALANCE_KP:    balance_kp_reg    <= cfg_wdata[18:0];
                brcc_pkg::CFG_BALANCE_KD:    balance_kd_reg    <= cfg_wdata[16:0];
                brcc_pkg::CFG_SPEED_KP:      speed_kp_reg      <= cfg_wdata[16:0];
                brcc_pkg::CFG_SPEED_KI:      speed_ki_reg      <= cfg_wdata[16:0];
                brcc_pkg::CFG_TURN_KP:       turn_kp_reg       <= cfg_wdata[16:0];
                brcc_pkg::CFG_TURN_KD:       turn_kd_reg       <= cfg_wdata[16:0];
                brcc_pkg::CFG_BALANCE_ANGLE: balance_angle_reg <= cfg_wdata[15:0];
                brcc_pkg::CFG_PWM_LIMIT:     pwm_limit_reg     <= cfg_wdata[14:0];
            endcase
        end
    end

    // Remote decode and target ramp; the ramp sees the freshly updated latch.
    always_comb begin
        dir_latch_next = dir_latch_reg;
        unique case (in_reg.remote_code) inside
            brcc_pkg::REM_STOP, brcc_pkg::REM_STOP_LF: dir_latch_next = brcc_pkg::DIR_NONE;
            brcc_pkg::REM_FWD:   dir_latch_next = brcc_pkg::DIR_FWD;
            brcc_pkg::REM_BACK:  dir_latch_next = brcc_pkg::DIR_BACK;
            brcc_pkg::REM_LEFT:  dir_latch_next = brcc_pkg::DIR_LEFT;
            brcc_pkg::REM_RIGHT: dir_latch_next = brcc_pkg::DIR_RIGHT;
            default:             dir_latch_next = dir_latch_reg;
        endcase

        if (dir_latch_next == brcc_pkg::DIR_FWD) begin
            target_next = (target_reg >= brcc_pkg::TARGET_MAX) ?
                          brcc_pkg::TARGET_MAX : target_reg + 8'sd1;
        end else if (dir_latch_next == brcc_pkg::DIR_BACK) begin
            target_next = (target_reg <= brcc_pkg::TARGET_MIN) ?
                          brcc_pkg::TARGET_MIN : target_reg - 8'sd1;
        end else begin
            target_next = '0;
        end

        if (dir_latch_reg == brcc_pkg::DIR_LEFT) begin
            turn_cmd = brcc_pkg::TURN_CMD;
        end else if (dir_latch_reg == brcc_pkg::DIR_RIGHT) begin
            turn_cmd = -brcc_pkg::TURN_CMD;
        end else begin
            turn_cmd = '0;
        end
    end

    // Shared multiplier operand select.
    always_comb begin
        bias       = 17'(in_reg.pitch_angle) - 17'(balance_angle_reg);
        prate_x100 = (23'(in_reg.pitch_rate) <<< 6) + (23'(in_reg.pitch_rate) <<< 5)
                   + (23'(in_reg.pitch_rate) <<< 2);
        unique case (cmd.mul_op)
            brcc_pkg::MUL_BAL_KP: begin
                mul_a = brcc_pkg::MUL_A_W'(bias);
                mul_b = brcc_pkg::MUL_B_W'(balance_kp_reg);
            end
            brcc_pkg::MUL_BAL_KD: begin
                mul_a = brcc_pkg::MUL_A_W'(prate_x100);
                mul_b = brcc_pkg::MUL_B_W'(balance_kd_reg);
            end
            brcc_pkg::MUL_TURN_KD: begin
                mul_a = brcc_pkg::MUL_A_W'(in_reg.yaw_rate);
                mul_b = brcc_pkg::MUL_B_W'(turn_kd_reg);
            end
            brcc_pkg::MUL_TURN_KP: begin
                mul_a = brcc_pkg::MUL_A_W'(turn_cmd);
                mul_b = brcc_pkg::MUL_B_W'(turn_kp_reg);
            end
            brcc_pkg::MUL_SPD_KP: begin
                mul_a = brcc_pkg::MUL_A_W'(fs_reg);
                mul_b = brcc_pkg::MUL_B_W'(speed_kp_reg);
            end
            brcc_pkg::MUL_SPD_KI: begin
                mul_a = brcc_pkg::MUL_A_W'(integ_reg);
                mul_b = brcc_pkg::MUL_B_W'(speed_ki_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = brcc_pkg::MUL_P_W'(mul_a) * brcc_pkg::MUL_P_W'(mul_b);
    end

    // Divider operands: magnitudes, with the sign kept aside. The upright
    // magnitude loses its power-of-two part of the scale before the divider.
    always_comb begin
        wheel_sum = 17'(in_reg.right_count) - 17'(in_reg.left_count);
        fsn       = (brcc_pkg::FSN_W'(fs_reg) <<< 2)
                  + (brcc_pkg::FSN_W'(wheel_sum) <<< brcc_pkg::FRAC_BITS);
        fsn_mag   = fsn[brcc_pkg::FSN_W-1] ? brcc_pkg::FSN_W'(-fsn) : brcc_pkg::FSN_W'(fsn);
        bal_mag   = bal_acc_reg[brcc_pkg::BAL_ACC_W-1] ?
                    brcc_pkg::BAL_ACC_W'(-bal_acc_reg) : brcc_pkg::BAL_ACC_W'(bal_acc_reg);
        div_start = cmd.div_fs | cmd.div_bal;
        if (cmd.div_fs) begin
            div_dividend = brcc_pkg::DIV_W'(fsn_mag);
        end else begin
            div_dividend = brcc_pkg::DIV_W'(bal_mag >> brcc_pkg::BAL_PRE_SH);
        end
    end

    brcc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .use_bal  (cmd.div_bal),
        .dividend (div_dividend),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Signed quotients, integral update, truncating scales and output clamp.
    always_comb begin
        q_s = $signed({1'b0, div_q});
        if (q_neg_reg) begin
            q_s = -q_s;
        end

        int_lim = brcc_pkg::INT_SUM_W'(brcc_pkg::INT_LIMIT);
        isum    = brcc_pkg::INT_SUM_W'(integ_reg) + brcc_pkg::INT_SUM_W'(fs_reg)
                - (brcc_pkg::INT_SUM_W'(target_reg) <<< brcc_pkg::FRAC_BITS);
        if (isum > int_lim) begin
            isum = int_lim;
        end else if (isum < -int_lim) begin
            isum = -int_lim;
        end

        spd_adj  = spd_acc_reg[brcc_pkg::SPD_ACC_W-1] ? spd_acc_reg + brcc_pkg::SPD_RND
                                                      : spd_acc_reg;
        spd_sh   = spd_adj >>> (2 * brcc_pkg::FRAC_BITS);
        spd_t    = spd_sh[brcc_pkg::SPD_T_W-1:0];
        turn_adj = turn_acc_reg[brcc_pkg::TURN_ACC_W-1] ? turn_acc_reg + brcc_pkg::TURN_RND
                                                        : turn_acc_reg;
        turn_sh  = turn_adj >>> brcc_pkg::FRAC_BITS;
        turn_t   = turn_sh[brcc_pkg::TURN_T_W-1:0];

        lim_s     = brcc_pkg::SUM_W'($signed({1'b0, pwm_limit_reg}));
        left_sum  = base_reg + turn_reg;
        right_sum = base_reg - turn_reg;
        if (left_sum > lim_s) begin
            left_clip = lim_s;
        end else if (left_sum < -lim_s) begin
            left_clip = -lim_s;
        end else begin
            left_clip = left_sum;
        end
        if (right_sum > lim_s) begin
            right_clip = lim_s;
        end else if (right_sum < -lim_s) begin
            right_clip = -lim_s;
        end else begin
            right_clip = right_sum;
        end

        pitch_tilted = (in_reg.pitch_angle > brcc_pkg::PITCH_CLEAR_LIM)
                     || (in_reg.pitch_angle < -brcc_pkg::PITCH_CLEAR_LIM);
    end

    // Persistent controller state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg        <= '0;
            integ_reg     <= '0;
            target_reg    <= '0;
            dir_latch_reg <= brcc_pkg::DIR_NONE;
        end else begin
            if (cmd.prep) begin
                dir_latch_reg <= dir_latch_next;
                target_reg    <= target_next;
            end
            if (cmd.fs_upd) begin
                fs_reg <= q_s[brcc_pkg::FS_W-1:0];
            end
            if (cmd.int_upd) begin
                integ_reg <= isum[brcc_pkg::INT_W-1:0];
            end else if (cmd.int_clr && pitch_tilted) begin
                integ_reg <= '0;
            end
        end
    end

    // Product tag is registered alongside the product, so the two stay aligned.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_dst_reg <= brcc_pkg::MUL_NONE;
        end else begin
            prod_dst_reg <= cmd.mul_op;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.load) begin
            in_reg       <= s_data;
            bal_acc_reg  <= '0;
            turn_acc_reg <= '0;
            spd_acc_reg  <= '0;
        end else begin
            case (prod_dst_reg) inside
                brcc_pkg::MUL_BAL_KP, brcc_pkg::MUL_BAL_KD: begin
                    bal_acc_reg <= bal_acc_reg + $signed(prod_reg[brcc_pkg::BAL_ACC_W-1:0]);
                end
                brcc_pkg::MUL_TURN_KD, brcc_pkg::MUL_TURN_KP: begin
                    turn_acc_reg <= turn_acc_reg
                                  + $signed(prod_reg[brcc_pkg::TURN_ACC_W-1:0]);
                end
                brcc_pkg::MUL_SPD_KP, brcc_pkg::MUL_SPD_KI: begin
                    spd_acc_reg <= spd_acc_reg + $signed(prod_reg[brcc_pkg::SPD_ACC_W-1:0]);
                end
                default: begin
                end
            endcase
        end
        if (cmd.div_fs) begin
            q_neg_reg <= fsn[brcc_pkg::FSN_W-1];
        end else if (cmd.div_bal) begin
            q_neg_reg <= bal_acc_reg[brcc_pkg::BAL_ACC_W-1];
        end
        if (cmd.result_prep) begin
            base_reg <= brcc_pkg::SUM_W'(q_s) + brcc_pkg::SUM_W'(spd_t);
            turn_reg <= brcc_pkg::SUM_W'(turn_t);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.left_drive       <= left_clip[15:0];
            m_data_reg.right_drive      <= right_clip[15:0];
            m_data_reg.integral_cleared <= pitch_tilted;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_data           = m_data_reg;
    assign status.div_busy  = div_busy;
    assign status.out_stall = m_valid_reg & ~m_ready;

endmodule

// ----- rtl/core/brcc_ctrl.sv -----
// Controller state machine that sequences one control tick through the datapath.
module brcc_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  brcc_pkg::brcc_status_t  status,
    output brcc_pkg::brcc_cmd_t     cmd
);

    brcc_pkg::brcc_state_t state_reg;
    brcc_pkg::brcc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= brcc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            brcc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = brcc_pkg::ST_PREP;
                end
            end
            brcc_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                cmd.div_fs = 1'b1;
                cmd.mul_op = brcc_pkg::MUL_BAL_KP;
                state_next = brcc_pkg::ST_MUL_BKD;
            end
            brcc_pkg::ST_MUL_BKD: begin
                cmd.mul_op = brcc_pkg::MUL_BAL_KD;
                state_next = brcc_pkg::ST_MUL_TKD;
            end
            brcc_pkg::ST_MUL_TKD: begin
                cmd.mul_op = brcc_pkg::MUL_TURN_KD;
                state_next = brcc_pkg::ST_MUL_TKP;
            end
            brcc_pkg::ST_MUL_TKP: begin
                cmd.mul_op = brcc_pkg::MUL_TURN_KP;
                state_next = brcc_pkg::ST_WAIT_FS;
            end
            brcc_pkg::ST_WAIT_FS: begin
                if (!status.div_busy) begin
                    state_next = brcc_pkg::ST_FS_UPD;
                end
            end
            brcc_pkg::ST_FS_UPD: begin
                cmd.fs_upd = 1'b1;
                state_next = brcc_pkg::ST_INT_UPD;
            end
            brcc_pkg::ST_INT_UPD: begin
                cmd.int_upd = 1'b1;
                cmd.div_bal = 1'b1;
                state_next  = brcc_pkg::ST_MUL_SKP;
            end
            brcc_pkg::ST_MUL_SKP: begin
                cmd.mul_op = brcc_pkg::MUL_SPD_KP;
                state_next = brcc_pkg::ST_MUL_SKI;
            end
            brcc_pkg::ST_MUL_SKI: begin
                // The integral is read here, then cleared on a large tilt.
                cmd.mul_op  = brcc_pkg::MUL_SPD_KI;
                cmd.int_clr = 1'b1;
                state_next  = brcc_pkg::ST_DRAIN;
            end
            brcc_pkg::ST_DRAIN: begin
                state_next = brcc_pkg::ST_WAIT_BAL;
            end
            brcc_pkg::ST_WAIT_BAL: begin
                if (!status.div_busy) begin
                    state_next = brcc_pkg::ST_RESULT_PREP;
                end
            end
            brcc_pkg::ST_RESULT_PREP: begin
                cmd.result_prep = 1'b1;
                state_next      = brcc_pkg::ST_RESULT;
            end
            brcc_pkg::ST_RESULT: begin
                if (!status.out_stall) begin
                    cmd.out_load = 1'b1;
                    state_next   = brcc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = brcc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/balance_robot_cascade_controller.sv -----
// Top level of the two-wheel balance robot cascade controller.
//
//   Channel  Ports                          Moves
//   -------  -----------------------------  -----------------------------------------
//   input    s_valid, s_ready, s_data       one sensor request per control tick
//   result   m_valid, m_ready, m_data       left and right drives, integral-clear flag
//   config   cfg_wr_en, cfg_index, cfg_wdata  gain, offset and limit register writes
//
// s_ready returns in the cycle after a result lands in the output register, so the
// block takes no new request before it is through with the last one. The controller
// sequence runs six products through the shared multiplier and two reciprocal
// divisions (speed filter, then upright scale). Reset is synchronous and active low;
// it restores the register defaults and clears the speed filter, integral, target and
// direction latch. A new request is taken while the previous result still waits in
// the output register; only the final load of a result waits for m_ready, for as
// long as the previous result stays untaken.
module balance_robot_cascade_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  brcc_pkg::brcc_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output brcc_pkg::brcc_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [brcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [brcc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    brcc_pkg::brcc_cmd_t    ctrl_cmd;
    brcc_pkg::brcc_status_t dp_status;

    // The controller owns sequencing; the datapath holds every value.
    brcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    brcc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (ctrl_cmd),
        .status    (dp_status)
    );

`ifndef ASSERT_OFF
    // One request at a time: the input closes right after an acceptance.
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted a second request back to back");

    // A result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register loaded while holding an untaken result");

    // The divider is never restarted in the middle of a pass.
    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_cmd.div_fs || ctrl_cmd.div_bal) |-> !dp_status.div_busy)
        else $error("divider started while busy");

    // A result appears only as the end of a sequenced request.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctrl_cmd.out_load))
        else $error("result appeared without a result load");
`endif

endmodule

// ----- tb/sv/balance_robot_cascade_controller_tb.sv -----
// Self-checking testbench for the balance robot cascade controller.
`timescale 1ns / 100ps

module balance_robot_cascade_controller_tb;
    import brcc_pkg::*;

    // One fixed-point unit of the gains and of the speed state.
    localparam longint ONE = longint'(1) << FRAC_BITS;
    // Fixed long receiver hold-off, and how often (in results) it happens.
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_INTERVAL = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic      s_valid = 1'b0;
    logic      s_ready;
    brcc_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    brcc_out_t m_data;

    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    balance_robot_cascade_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Sensor requests waiting to be offered, and drive results that the
    // accepted requests are predicted to produce, oldest first.
    brcc_in_t  sensor_pending[$];
    brcc_out_t drive_expect[$];

    // Our own copy of the gain, offset and limit registers.
    longint bal_kp, bal_kd, spd_kp, spd_ki, trn_kp, trn_kd, bal_ang, drv_lim;

    // Our own copy of the controller state.
    longint     fs_q;
    longint     integ_q;
    longint     target_q;
    logic [3:0] dir_q;

    // When set, neither side inserts random gaps.
    logic no_idle = 1'b0;

    int send_gap = 0;
    int ready_gap = 0;
    int ready_gap_next;

    int sent_count = 0;
    int results_seen = 0;
    int fail_count = 0;
    int clear_count = 0;
    int fwd_sat_count = 0;
    int back_sat_count = 0;
    int setting_count = 1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: far beyond the slowest legal run, including every long
    // receiver hold-off and the longest sender gaps on every request.
    initial begin
        #15_000_000;
        $display("** balance_robot_cascade_controller: FAILED **");
        $finish;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Mostly back-to-back, often a few cycles, now and then a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int rand_span(input int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    // One control tick: update the latch, target, filter and integral, then
    // form the two saturated drives exactly as the block should.
    function automatic void predict_drives(input brcc_in_t req);
        longint    pitch, prate, yrate, lcnt, rcnt;
        longint    cmd, bal, spd, turn, wheel_sum, d_left, d_right;
        logic      cleared;
        brcc_out_t res;

        pitch = longint'($signed(req.pitch_angle));
        prate = longint'($signed(req.pitch_rate));
        yrate = longint'($signed(req.yaw_rate));
        lcnt  = longint'($signed(req.left_count));
        rcnt  = longint'($signed(req.right_count));
        cleared = 1'b0;

        // Stop codes clear the latch, the four direction codes set exactly
        // one flag, anything else leaves it alone.
        case (req.remote_code)
            REM_STOP, REM_STOP_LF: dir_q = DIR_NONE;
            REM_FWD:               dir_q = DIR_FWD;
            REM_BACK:              dir_q = DIR_BACK;
            REM_LEFT:              dir_q = DIR_LEFT;
            REM_RIGHT:             dir_q = DIR_RIGHT;
            default:               ;
        endcase

        if (dir_q == DIR_FWD)
            target_q = clip(target_q + 1, TARGET_MIN, TARGET_MAX);
        else if (dir_q == DIR_BACK)
            target_q = clip(target_q - 1, TARGET_MIN, TARGET_MAX);
        else
            target_q = 0;
        if (target_q == TARGET_MAX) fwd_sat_count++;
        if (target_q == TARGET_MIN) back_sat_count++;

        if (dir_q == DIR_LEFT)       cmd = TURN_CMD;
        else if (dir_q == DIR_RIGHT) cmd = -longint'(TURN_CMD);
        else                         cmd = 0;

        // The upright gain is per degree while pitch is in hundredths.
        bal = (bal_kp * (pitch - bal_ang) + 100 * bal_kd * prate) / (100 * ONE);

        wheel_sum = rcnt - lcnt;
        fs_q = (4 * fs_q + wheel_sum * ONE) / 5;
        integ_q = clip(integ_q + fs_q - target_q * ONE, -longint'(INT_LIMIT),
                       longint'(INT_LIMIT));
        spd = (fs_q * spd_kp + integ_q * spd_ki) / (ONE * ONE);
        // The integral is used for this tick before a large tilt clears it.
        if (pitch < -longint'(PITCH_CLEAR_LIM) || pitch > longint'(PITCH_CLEAR_LIM)) begin
            integ_q = 0;
            cleared = 1'b1;
            clear_count++;
        end

        turn = (trn_kd * yrate + trn_kp * cmd) / ONE;

        d_left  = clip(bal + spd + turn, -drv_lim, drv_lim);
        d_right = clip(bal + spd - turn, -drv_lim, drv_lim);

        res.left_drive       = d_left[15:0];
        res.right_drive      = d_right[15:0];
        res.integral_cleared = cleared;
        drive_expect.push_back(res);
    endfunction

    // Sender: offers queued sensor requests with random gaps between them
    // and predicts each one at the edge where it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_drives(s_data);
                sent_count++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (sensor_pending.size() != 0) begin
                    s_data   <= sensor_pending.pop_front();
                    s_valid  <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every accepted result against the oldest prediction
    // and drops ready at random. Every few hundred results it holds off for
    // a long stretch so the block fills up and has to stall its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            ready_gap <= 0;
        end else begin
            ready_gap_next = ready_gap;
            if (m_valid && m_ready) begin
                results_seen++;
                if (drive_expect.size() == 0) begin
                    $error("result with no request outstanding: left %0d right %0d clr %0b",
                           $signed(m_data.left_drive), $signed(m_data.right_drive),
                           m_data.integral_cleared);
                    fail_count++;
                end else begin
                    brcc_out_t want;
                    want = drive_expect.pop_front();
                    if (m_data.left_drive !== want.left_drive) begin
                        $error("left_drive: expected %0d, got %0d",
                               $signed(want.left_drive), $signed(m_data.left_drive));
                        fail_count++;
                    end
                    if (m_data.right_drive !== want.right_drive) begin
                        $error("right_drive: expected %0d, got %0d",
                               $signed(want.right_drive), $signed(m_data.right_drive));
                        fail_count++;
                    end
                    if (m_data.integral_cleared !== want.integral_cleared) begin
                        $error("integral_cleared: expected %0b, got %0b",
                               want.integral_cleared, m_data.integral_cleared);
                        fail_count++;
                    end
                end
                if (results_seen % HOLD_INTERVAL == HOLD_INTERVAL / 2)
                    ready_gap_next = LONG_HOLD;
                else
                    ready_gap_next = pick_gap();
            end
            if (ready_gap_next > 0) begin
                m_ready   <= 1'b0;
                ready_gap <= ready_gap_next - 1;
            end else begin
                m_ready   <= 1'b1;
                ready_gap <= 0;
            end
        end
    end

    // Register write: one cycle with the enable high, then the model copy
    // takes the value as the block sees it, cut to the register's width.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_BALANCE_KP:    bal_kp  = longint'($signed(val[18:0]));
            CFG_BALANCE_KD:    bal_kd  = longint'($signed(val[16:0]));
            CFG_SPEED_KP:      spd_kp  = longint'($signed(val[16:0]));
            CFG_SPEED_KI:      spd_ki  = longint'($signed(val[16:0]));
            CFG_TURN_KP:       trn_kp  = longint'($signed(val[16:0]));
            CFG_TURN_KD:       trn_kd  = longint'($signed(val[16:0]));
            CFG_BALANCE_ANGLE: bal_ang = longint'($signed(val[15:0]));
            CFG_PWM_LIMIT:     drv_lim = longint'(val[14:0]);
            default:           ;
        endcase
    endtask

    task automatic set_registers(input int kp, input int kd, input int skp, input int ski,
                                 input int tkp, input int tkd, input int ang, input int lim);
        write_reg(CFG_BALANCE_KP, CFG_DATA_W'(kp));
        write_reg(CFG_BALANCE_KD, CFG_DATA_W'(kd));
        write_reg(CFG_SPEED_KP, CFG_DATA_W'(skp));
        write_reg(CFG_SPEED_KI, CFG_DATA_W'(ski));
        write_reg(CFG_TURN_KP, CFG_DATA_W'(tkp));
        write_reg(CFG_TURN_KD, CFG_DATA_W'(tkd));
        write_reg(CFG_BALANCE_ANGLE, CFG_DATA_W'(ang));
        write_reg(CFG_PWM_LIMIT, CFG_DATA_W'(lim));
        setting_count++;
    endtask

    task automatic push_sensor(input int pitch, input int prate, input int yrate,
                               input int lcnt, input int rcnt, input logic [7:0] code);
        brcc_in_t req;
        req.pitch_angle = 16'(pitch);
        req.pitch_rate  = 16'(prate);
        req.yaw_rate    = 16'(yrate);
        req.left_count  = 16'(lcnt);
        req.right_count = 16'(rcnt);
        req.remote_code = code;
        sensor_pending.push_back(req);
    endtask

    // Sensor readings: mostly a robot near upright with modest wheel counts,
    // sometimes a large tilt, sometimes raw bit patterns over the full width.
    function automatic brcc_in_t rand_sensors();
        brcc_in_t r;
        int       sel;
        sel = $urandom_range(9);
        if (sel == 9) begin
            r.pitch_angle = 16'($urandom);
            r.pitch_rate  = 16'($urandom);
            r.yaw_rate    = 16'($urandom);
            r.left_count  = 16'($urandom);
            r.right_count = 16'($urandom);
        end else begin
            r.pitch_angle = 16'((sel < 7) ? rand_span(3500) : rand_span(18000));
            r.pitch_rate  = 16'(rand_span(2000));
            r.yaw_rate    = 16'(rand_span(2000));
            r.left_count  = 16'((sel == 8) ? rand_span(32767) : rand_span(300));
            r.right_count = 16'((sel == 8) ? rand_span(32767) : rand_span(300));
        end
        r.remote_code = 8'($urandom);
        return r;
    endfunction

    // Random traffic shaped like remote driving: a command byte starts a run
    // of ticks, and within the run most ticks carry bytes that leave the
    // latch alone, so long runs ramp the target into its limits. A few ticks
    // repeat the command or carry an arbitrary byte.
    task automatic queue_drive_runs(input int count);
        brcc_in_t   req;
        int         left, run_len, i;
        logic [7:0] cmd_code;
        left = count;
        while (left > 0) begin
            run_len = $urandom_range(1, ($urandom_range(3) == 0) ? 150 : 20);
            case ($urandom_range(5))
                0:       cmd_code = REM_STOP;
                1:       cmd_code = REM_STOP_LF;
                2:       cmd_code = REM_FWD;
                3:       cmd_code = REM_BACK;
                4:       cmd_code = REM_LEFT;
                default: cmd_code = REM_RIGHT;
            endcase
            for (i = 0; i < run_len && left > 0; i++) begin
                req = rand_sensors();
                if (i == 0) begin
                    req.remote_code = cmd_code;
                end else begin
                    case ($urandom_range(9))
                        0:       ;
                        1, 2:    req.remote_code = cmd_code;
                        default: req.remote_code = 8'($urandom_range(REM_RIGHT + 1, 255));
                    endcase
                end
                sensor_pending.push_back(req);
                left--;
            end
        end
    endtask

    // Waits until every queued request went in and every result came out,
    // then lets the divider pipeline settle before anything else happens.
    task automatic wait_drained();
        do @(negedge aclk);
        while (sensor_pending.size() != 0 || s_valid || drive_expect.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        bal_kp  = RST_BALANCE_KP;
        bal_kd  = RST_BALANCE_KD;
        spd_kp  = RST_SPEED_KP;
        spd_ki  = RST_SPEED_KI;
        trn_kp  = RST_TURN_KP;
        trn_kd  = RST_TURN_KD;
        bal_ang = RST_BALANCE_ANGLE;
        drv_lim = RST_PWM_LIMIT;
        fs_q     = 0;
        integ_q  = 0;
        target_q = 0;
        dir_q    = DIR_NONE;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the reset register values. They walk the
        // remote codes (both stop bytes, each direction, bytes that are
        // ignored), the pitch just inside and just outside the clear band,
        // and the full-scale ends of every sensor field.
        push_sensor(0, 0, 0, 0, 0, 8'd0);
        push_sensor(0, 0, 0, 0, 0, REM_FWD);
        push_sensor(18000, 32767, 32767, -32768, 32767, REM_FWD);
        push_sensor(-18000, -32768, -32768, 32767, -32768, REM_BACK);
        push_sensor(100, 0, 32767, 5, 5, REM_LEFT);
        push_sensor(-100, 0, -32768, -5, -5, REM_RIGHT);
        push_sensor(0, 32767, 0, 0, 0, REM_STOP);
        push_sensor(0, -32768, 0, 0, 0, REM_STOP_LF);
        push_sensor(4000, 10, 10, 1, 2, 8'd255);
        push_sensor(4001, 10, 10, 1, 2, 8'd7);
        push_sensor(-4000, -10, -10, 2, 1, REM_FWD);
        push_sensor(-4001, -10, -10, 2, 1, 8'd200);
        push_sensor(200, 0, 0, 0, 0, 8'd128);
        // A run of full-speed wheel counts drives the filter up and the
        // integral into its upper clamp, then the other way.
        repeat (5) push_sensor(0, 0, 0, -32768, 32767, 8'd53);
        repeat (5) push_sensor(0, 0, 0, 32767, -32768, 8'd1);
        push_sensor(-32768, 0, 0, 0, 0, REM_STOP);
        push_sensor(32767, 0, 0, 0, 0, REM_BACK);
        queue_drive_runs(300);
        wait_drained();

        // Upper extremes of every register but the balance angle, which is set to 18000.
        set_registers(262143, 65535, 65535, 65535, 65535, 65535, 18000, 32767);
        queue_drive_runs(260);
        wait_drained();

        // Lower extremes of every register but the balance angle; a zero limit forces both drives to zero.
        set_registers(-262144, -65536, -65536, -65536, -65536, -65536, -18000, 0);
        queue_drive_runs(260);
        wait_drained();

        // Smallest nonzero limit with moderate gains.
        set_registers(50000, -300, 12000, -200, 5000, 400, 300, 1);
        queue_drive_runs(260);
        wait_drained();

        // Raw random register bit patterns, out-of-range values included.
        set_registers($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        queue_drive_runs(260);
        wait_drained();

        // Gains scattered around the reset values with a random limit.
        set_registers(RST_BALANCE_KP + rand_span(20000), RST_BALANCE_KD + rand_span(200),
                      RST_SPEED_KP + rand_span(8000), RST_SPEED_KI + rand_span(100),
                      RST_TURN_KP + rand_span(2000), RST_TURN_KD + rand_span(100),
                      rand_span(1000), $urandom_range(0, 32767));
        queue_drive_runs(260);
        wait_drained();

        // Back to the reset values with neither side inserting random gaps.
        no_idle = 1'b1;
        set_registers(RST_BALANCE_KP, RST_BALANCE_KD, RST_SPEED_KP, RST_SPEED_KI,
                      RST_TURN_KP, RST_TURN_KD, RST_BALANCE_ANGLE, RST_PWM_LIMIT);
        queue_drive_runs(260);
        wait_drained();

        // Allow for anything that would still trickle out of the block.
        repeat (60) @(posedge aclk);

        $display("Checked %0d drive results from %0d sensor requests over %0d register settings.",
                 results_seen, sent_count, setting_count);
        $display("Integral cleared on %0d ticks; target held at +100 on %0d, at -100 on %0d.",
                 clear_count, fwd_sat_count, back_sat_count);
        if (fail_count == 0)
            $display("** balance_robot_cascade_controller: PASSED **");
        else
            $display("** balance_robot_cascade_controller: FAILED **");
        $finish;
    end

endmodule
